// ----- src/aaema_pkg.sv -----
// Package for the two-channel ADC averager: widths, reset values, register indexes, types.
`default_nettype none

package aaema_pkg;

    // Default build parameters
    localparam int SAMPLES_PER_GROUP_DEF = 4;
    localparam int GAIN_FRAC_BITS_DEF    = 16;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int GAIN_W     = 32;
    localparam int OFFS_W     = 16;
    localparam int ALPHA_W    = 9;
    localparam int ALPHA_FRAC = 8;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Saturation limit on the group average, in counts
    localparam int SAT_LIMIT  = 32000;
    localparam int ALPHA_HALF = 128;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_ALPHA   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_THR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_THR     = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_GAIN         = 32'hFFFF_0000;
    localparam logic [OFFS_W-1:0]  RST_OFFSET       = 16'h0000;
    localparam logic [ALPHA_W-1:0] RST_NORMAL_ALPHA = 9'd64;
    localparam logic [ALPHA_W-1:0] RST_JUMP_ALPHA   = 9'd218;
    localparam logic [THR_W-1:0]   RST_VOLT_THR     = 31'd1000;
    localparam logic [THR_W-1:0]   RST_CURR_THR     = 31'd150;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_sample;
        logic                       channel;
    } in_item_t;

    typedef struct packed {
        logic                      out_channel;
        logic signed [VALUE_W-1:0] filtered_value;
        logic                      saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_DIV,
        ST_SCALE,
        ST_FILT,
        ST_FROUND,
        ST_FDONE
    } state_t;

endpackage

`default_nettype wire

// ----- src/adc_average_adaptive_ema.sv -----
// Two-channel ADC averager with Q16 scaling and adaptive exponential smoothing.
//
// Input beats (in_valid/in_stall) carry a signed 16-bit conversion and a channel
// tag (0 voltage, 1 current). Each channel sums SAMPLES_PER_GROUP of its own
// samples; a beat that does not close a group is taken while idle and gives
// no result. A beat that closes a group gives one output beat (out_valid/out_stall)
// holding the channel, the filtered reading and the saturation flag.
// One bit-serial shift-add multiplier (33 steps, used for the gain and again
// for alpha; the first reading of a channel skips the alpha pass) and a
// bit-serial divider by the group size (Q steps) do the work, where
// Q = 34 + SUM_W - GAIN_FRAC_BITS and SUM_W = 16 + clog2(SAMPLES_PER_GROUP).
// in_stall is high from a group close until the result sits in the output
// register. A stalled output beat holds; the next group result waits for it
// in the result state, and no samples are taken meanwhile. Reset clears the group
// sums, counts, filter state and the output valid, and loads the register defaults.
// The cfg port (cfg_we, cfg_index, cfg_data) writes one register a cycle; the user
// must use it only while the block is idle, as the block does not enforce this.
`default_nettype none

module adc_average_adaptive_ema
    import aaema_pkg::*;
#(
    parameter int SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
    parameter int GAIN_FRAC_BITS    = GAIN_FRAC_BITS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire in_item_t              in_data,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      out_item_t             out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES_PER_GROUP);
    localparam int D_W     = SUM_W + 1;
    localparam int MA_W    = SUM_W;
    localparam int MB_W    = VALUE_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int QW      = ACC_W - GAIN_FRAC_BITS;
    localparam int QX_W    = (QW > MB_W) ? QW : MB_W;
    localparam int RW      = $clog2(SAMPLES_PER_GROUP) + 1;
    localparam int GCNT_W  = $clog2(SAMPLES_PER_GROUP + 1);
    localparam int MAXC    = (QW > MB_W) ? QW : MB_W;
    localparam int CNT_W   = $clog2(MAXC + 1);
    localparam int STEP_W  = MB_W + ALPHA_W;
    localparam int NEW_W   = STEP_W - ALPHA_FRAC;

    localparam logic [SUM_W-1:0]  SAT_LIM    = SUM_W'(SAT_LIMIT * SAMPLES_PER_GROUP);
    localparam logic [ACC_W-1:0]  HALF_DEN   = ACC_W'(SAMPLES_PER_GROUP) << (GAIN_FRAC_BITS - 1);
    localparam logic [RW:0]       DIV_N      = (RW + 1)'(SAMPLES_PER_GROUP);
    localparam logic [GCNT_W-1:0] GCNT_LAST  = GCNT_W'(SAMPLES_PER_GROUP - 1);
    localparam logic [CNT_W-1:0]  MUL_STEPS  = CNT_W'(MB_W);
    localparam logic [CNT_W-1:0]  DIV_STEPS  = CNT_W'(QW);
    localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(1);
    localparam logic [STEP_W-1:0] STEP_HALF  = STEP_W'(ALPHA_HALF);

    // Configuration registers
    logic signed [GAIN_W-1:0] volt_gain_reg, curr_gain_reg;
    logic signed [OFFS_W-1:0] volt_offset_reg, curr_offset_reg;
    logic [ALPHA_W-1:0]       normal_alpha_reg, jump_alpha_reg;
    logic [THR_W-1:0]         volt_thr_reg, curr_thr_reg;

    // Per-channel state
    logic [SUM_W-1:0]   gsum_reg   [2];
    logic [SUM_W-1:0]   gsum_next  [2];
    logic [GCNT_W-1:0]  gcnt_reg   [2];
    logic [GCNT_W-1:0]  gcnt_next  [2];
    logic [VALUE_W-1:0] fval_reg   [2];
    logic [VALUE_W-1:0] fval_next  [2];
    logic               primed_reg [2];
    logic               primed_next[2];

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [MA_W-1:0]    mcand_reg, mcand_next;
    logic [QW-1:0]      quot_reg, quot_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic               sign_reg, sign_next;
    logic               dsign_reg, dsign_next;
    logic               alpha_pass_reg, alpha_pass_next;
    logic               ch_reg, ch_next;
    logic               sat_reg, sat_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [VALUE_W-1:0] scaled_reg, scaled_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath helpers
    logic                     in_ch;
    logic [SUM_W-1:0]         in_sum;
    logic                     in_last;
    logic signed [GAIN_W-1:0] cur_gain;
    logic signed [OFFS_W-1:0] cur_offs;
    logic [THR_W-1:0]         cur_thr;
    logic [D_W-1:0]           offs_n;
    logic [D_W-1:0]           d_val;
    logic [D_W-1:0]           d_neg_val;
    logic [MA_W-1:0]          d_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic [MB_W-1:0]          gain_x;
    logic [MB_W-1:0]          gain_mag;
    logic [MA_W:0]            mul_hi_sum;
    logic [ACC_W-1:0]         mul_shift;
    logic [ACC_W-1:0]         rnd_val;
    logic [RW:0]              trial;
    logic                     trial_ge;
    logic [RW:0]              trial_sub;
    logic [QX_W-1:0]          qx;
    logic                     over_pos, over_neg;
    logic [VALUE_W-1:0]       scaled_val;
    logic [VALUE_W-1:0]       prev_val;
    logic [MB_W-1:0]          diff;
    logic [MB_W-1:0]          adiff;
    logic                     jump;
    logic [ALPHA_W-1:0]       alpha_sel;
    logic [ALPHA_W-1:0]       alpha_eff;
    logic [STEP_W-1:0]        step_rnd;
    logic [NEW_W-1:0]         step_mag;
    logic [NEW_W-1:0]         new_val;
    logic [VALUE_W-1:0]       new_sat;

    // Accumulate the incoming beat into its channel's group
    assign in_ch   = in_data.channel;
    assign in_sum  = gsum_reg[in_ch] + SUM_W'(in_data.raw_sample);
    assign in_last = (gcnt_reg[in_ch] == GCNT_LAST);

    // Select the working channel's registers
    assign cur_gain = ch_reg ? curr_gain_reg : volt_gain_reg;
    assign cur_offs = ch_reg ? curr_offset_reg : volt_offset_reg;
    assign cur_thr  = ch_reg ? curr_thr_reg : volt_thr_reg;

    // Remove the offset in counts and split into sign and magnitude
    assign offs_n    = D_W'(cur_offs * SAMPLES_PER_GROUP);
    assign d_val     = {sum_reg[SUM_W-1], sum_reg} - offs_n;
    assign d_neg_val = -d_val;
    assign d_mag     = d_val[D_W-1] ? d_neg_val[MA_W-1:0] : d_val[MA_W-1:0];
    assign sum_mag   = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign gain_x    = MB_W'(cur_gain);
    assign gain_mag  = gain_x[MB_W-1] ? -gain_x : gain_x;

    // One shift-add multiplier step, LSB of the multiplier first
    assign mul_hi_sum = acc_reg[ACC_W-1:MB_W] + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_shift  = {mul_hi_sum, acc_reg[MB_W-1:0]} >> 1;

    // Round half away from zero on the magnitude, then drop the Q fraction
    assign rnd_val = {1'b0, acc_reg[PROD_W-1:0]} + HALF_DEN;

    // One restoring division step by the group size
    assign trial     = {rem_reg, quot_reg[QW-1]};
    assign trial_ge  = (trial >= DIV_N);
    assign trial_sub = trial - DIV_N;

    // Apply the sign and clamp to the 32-bit range
    assign qx       = QX_W'(quot_reg);
    assign over_pos = |qx[QX_W-1:VALUE_W-1];
    assign over_neg = (|qx[QX_W-1:VALUE_W]) | (qx[VALUE_W-1] & (|qx[VALUE_W-2:0]));
    always_comb
    begin
        if (sign_reg)
        begin
            scaled_val = over_neg ? VALUE_MIN : -qx[VALUE_W-1:0];
        end
        else
        begin
            scaled_val = over_pos ? VALUE_MAX : qx[VALUE_W-1:0];
        end
    end

    // Step from the previous filtered value and choose alpha
    assign prev_val  = fval_reg[ch_reg];
    assign diff      = {scaled_reg[VALUE_W-1], scaled_reg} - {prev_val[VALUE_W-1], prev_val};
    assign adiff     = diff[MB_W-1] ? -diff : diff;
    assign jump      = (adiff >= MB_W'(cur_thr));
    assign alpha_sel = jump ? jump_alpha_reg : normal_alpha_reg;
    assign alpha_eff = alpha_sel[ALPHA_W-1] ? ALPHA_ONE : alpha_sel;

    // Scale the weighted step back from alpha's Q1.8 and add it to the previous value
    assign step_rnd = acc_reg[STEP_W-1:0] + STEP_HALF;
    assign step_mag = step_rnd[STEP_W-1:ALPHA_FRAC];
    assign new_val  = {{(NEW_W - VALUE_W){prev_val[VALUE_W-1]}}, prev_val}
                      + (dsign_reg ? -step_mag : step_mag);
    always_comb
    begin
        if ((new_val[NEW_W-1:VALUE_W-1] == '0) || (new_val[NEW_W-1:VALUE_W-1] == '1))
        begin
            new_sat = new_val[VALUE_W-1:0];
        end
        else
        begin
            new_sat = new_val[NEW_W-1] ? VALUE_MIN : VALUE_MAX;
        end
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        sign_next       = sign_reg;
        dsign_next      = dsign_reg;
        alpha_pass_next = alpha_pass_reg;
        ch_next         = ch_reg;
        sat_next        = sat_reg;
        sum_next        = sum_reg;
        scaled_next     = scaled_reg;
        res_next        = res_reg;
        gsum_next       = gsum_reg;
        gcnt_next       = gcnt_reg;
        fval_next       = fval_reg;
        primed_next     = primed_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & out_stall;
        in_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_last)
                    begin
                        gsum_next[in_ch] = '0;
                        gcnt_next[in_ch] = '0;
                        sum_next         = in_sum;
                        ch_next          = in_ch;
                        state_next       = ST_LOAD;
                    end
                    else
                    begin
                        gsum_next[in_ch] = in_sum;
                        gcnt_next[in_ch] = gcnt_reg[in_ch] + 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                sat_next        = (sum_mag > SAT_LIM);
                sign_next       = d_val[D_W-1] ^ cur_gain[GAIN_W-1];
                mcand_next      = d_mag;
                acc_next        = {{(ACC_W - MB_W){1'b0}}, gain_mag};
                alpha_pass_next = 1'b0;
                cnt_next        = MUL_STEPS;
                state_next      = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next = mul_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = alpha_pass_reg ? ST_FROUND : ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                quot_next  = rnd_val[ACC_W-1:GAIN_FRAC_BITS];
                rem_next   = '0;
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
                quot_next = {quot_reg[QW-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scaled_next = scaled_val;
                state_next  = ST_FILT;
            end
            ST_FILT:
            begin
                if (!primed_reg[ch_reg])
                begin
                    // First reading passes straight through
                    fval_next[ch_reg]   = scaled_reg;
                    primed_next[ch_reg] = 1'b1;
                    res_next            = scaled_reg;
                    state_next          = ST_FDONE;
                end
                else
                begin
                    mcand_next      = MA_W'(alpha_eff);
                    acc_next        = {{(ACC_W - MB_W){1'b0}}, adiff};
                    dsign_next      = diff[MB_W-1];
                    alpha_pass_next = 1'b1;
                    cnt_next        = MUL_STEPS;
                    state_next      = ST_MUL;
                end
            end
            ST_FROUND:
            begin
                fval_next[ch_reg] = new_sat;
                res_next          = new_sat;
                state_next        = ST_FDONE;
            end
            ST_FDONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.out_channel    = ch_reg;
                    out_next.filtered_value = res_reg;
                    out_next.saturated      = sat_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_gain_reg    <= RST_GAIN;
            curr_gain_reg    <= RST_GAIN;
            volt_offset_reg  <= RST_OFFSET;
            curr_offset_reg  <= RST_OFFSET;
            normal_alpha_reg <= RST_NORMAL_ALPHA;
            jump_alpha_reg   <= RST_JUMP_ALPHA;
            volt_thr_reg     <= RST_VOLT_THR;
            curr_thr_reg     <= RST_CURR_THR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOLT_GAIN:    volt_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_CURR_GAIN:    curr_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_VOLT_OFFSET:  volt_offset_reg  <= cfg_data[OFFS_W-1:0];
                CFG_CURR_OFFSET:  curr_offset_reg  <= cfg_data[OFFS_W-1:0];
                CFG_NORMAL_ALPHA: normal_alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_JUMP_ALPHA:   jump_alpha_reg   <= cfg_data[ALPHA_W-1:0];
                CFG_VOLT_THR:     volt_thr_reg     <= cfg_data[THR_W-1:0];
                CFG_CURR_THR:     curr_thr_reg     <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    // Advance control state and per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            alpha_pass_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                gsum_reg[c]   <= '0;
                gcnt_reg[c]   <= '0;
                fval_reg[c]   <= '0;
                primed_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            alpha_pass_reg <= alpha_pass_next;
            out_valid_reg  <= out_valid_next;
            gsum_reg       <= gsum_next;
            gcnt_reg       <= gcnt_next;
            fval_reg       <= fval_next;
            primed_reg     <= primed_next;
        end
    end

    // Hold datapath and output payload
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        sign_reg   <= sign_next;
        dsign_reg  <= dsign_next;
        ch_reg     <= ch_next;
        sat_reg    <= sat_next;
        sum_reg    <= sum_next;
        scaled_reg <= scaled_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // A new output beat only ever comes from the result state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FDONE))
        else $error("output beat raised outside the result state");

    // A beat that closes a group starts the scaling sequence
    a_group_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_last) |=> (state_reg == ST_LOAD))
        else $error("group close did not start scaling");

    // The divider hands over to scaling after its last step
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == LAST_STEP) |=> (state_reg == ST_SCALE))
        else $error("divider did not finish on its last step");

    // A pending result waits while the output beat is stalled
    a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FDONE && out_valid && out_stall) |=> (state_reg == ST_FDONE))
        else $error("result left while output was stalled");
`endif

endmodule

`default_nettype wire
